### sv/eia_pkg.sv
// Shared types, constants and tables for the equisolid incidence angle block.
// Used by every module of the block; depends on nothing else.

package eia_pkg;

  localparam int NUM_COEFFS = 4;
  localparam int MAX_COEFFS = 4;

  localparam int DIV1_N    = 40;
  localparam int DIV2_N    = 31;
  localparam int SAR_N     = 17;
  localparam int SIN_TERMS = 7;
  localparam int CELL_DLY  = 1 + 3 * SIN_TERMS;
  localparam int CELL_LAT  = CELL_DLY + 1;

  localparam int FRONT_N = 1 + DIV1_N;
  localparam int U_DLY   = 3 * MAX_COEFFS - 3;
  localparam int ACC_N   = 3 * MAX_COEFFS - 2;
  localparam int SIDE1_N = 2 + DIV2_N;
  localparam int SIDE2_N = SAR_N * CELL_LAT;
  localparam int LAT     = FRONT_N + 3 * MAX_COEFFS + 7 + 3 + DIV2_N + SIDE2_N;

  localparam logic [39:0] CAP     = 40'hFF_FFFF_FFFF;
  localparam logic [30:0] ONE30   = 31'h4000_0000;
  localparam logic [16:0] PI_Q14  = 17'd51472;
  localparam logic [16:0] TOP_BIT = 17'h10000;

  localparam logic [2:0] REG_NS = 3'd0;
  localparam logic [2:0] REG_FL = 3'd1;
  localparam logic [2:0] REG_C0 = 3'd2;
  localparam logic [2:0] REG_C1 = 3'd3;
  localparam logic [2:0] REG_C2 = 3'd4;
  localparam logic [2:0] REG_C3 = 3'd5;

  // Divisors (2k)(2k+1) of the sine series and floor(2^34 / divisor).
  localparam logic [7:0] SIN_DVS [SIN_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                                  8'd156, 8'd210};
  localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{32'd2863311530, 32'd858993459,
                                                   32'd409044504, 32'd238609294,
                                                   32'd156180628, 32'd110127366,
                                                   32'd81808900};

  typedef struct packed {
    logic [20:0] rem;
    logic [39:0] num;
    logic [39:0] quo;
    logic [20:0] den;
  } div_t;

  typedef struct packed {
    logic [30:0]        tm;
    logic [31:0]        x2;
    logic signed [33:0] sum;
  } sin_t;

  typedef struct packed {
    logic [16:0] a;
    logic [16:0] mask;
    logic [30:0] tmag;
  } sar_t;

endpackage

### sv/eia_div_cell.sv
// One restoring division cell: resolves one quotient bit per transfer.
// Depends on eia_pkg for the division data type.

module eia_div_cell (
  input  logic          clk,
  input  logic          en,
  input  eia_pkg::div_t d_i,
  output eia_pkg::div_t d_o
);
  import eia_pkg::*;

  logic [21:0] t;
  logic        ge;
  div_t        d_r;

  assign t  = {d_i.rem, d_i.num[39]};
  assign ge = t >= {1'b0, d_i.den};

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.rem <= ge ? 21'(t - {1'b0, d_i.den}) : t[20:0];
      d_r.num <= {d_i.num[38:0], 1'b0};
      d_r.quo <= {d_i.quo[38:0], ge};
      d_r.den <= d_i.den;
    end
  end

  assign d_o = d_r;

endmodule

### sv/eia_mulq.sv
// Three-stage Q.30 multiplier: floor(a * b / 2^30), saturated to the cap.
// Built from four 20 by 20 bit partial products; depends on eia_pkg.

module eia_mulq (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] a_i,
  input  logic [39:0] b_i,
  output logic [39:0] p_o
);
  import eia_pkg::*;

  logic [39:0] ll_r, lh_r, hl_r, hh_r;
  logic [39:0] ll2_r, hh2_r;
  logic [40:0] mid_r;
  logic [79:0] full;
  logic [39:0] p_r;

  assign full = {hh2_r, ll2_r} + {19'b0, mid_r, 20'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= a_i[19:0] * b_i[19:0];
      lh_r  <= a_i[19:0] * b_i[39:20];
      hl_r  <= a_i[39:20] * b_i[19:0];
      hh_r  <= a_i[39:20] * b_i[39:20];
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      ll2_r <= ll_r;
      hh2_r <= hh_r;
      p_r   <= (full[79:70] != 10'b0) ? CAP : full[69:30];
    end
  end

  assign p_o = p_r;

endmodule

### sv/eia_sin_step.sv
// One term of the sine series: next term = floor(floor(term * x2 / 2^30) / d).
// The division by the constant d uses its reciprocal and one correction; uses eia_pkg.

module eia_sin_step (
  input  logic          clk,
  input  logic          en,
  input  eia_pkg::sin_t t_i,
  input  logic [7:0]    dvs_i,
  input  logic [31:0]   rcp_i,
  input  logic          sub_i,
  output eia_pkg::sin_t t_o
);
  import eia_pkg::*;

  logic [62:0]        y_r;
  logic [31:0]        x2a_r, x2b_r;
  logic signed [33:0] suma_r, sumb_r;
  logic [32:0]        y30_r;
  logic [64:0]        pq_r;
  logic [30:0]        q0, q;
  logic [33:0]        rmd;
  sin_t               t_r;

  assign q0  = pq_r[64:34];
  assign rmd = {1'b0, y30_r} - 34'(q0 * dvs_i);
  assign q   = q0 + 31'(rmd >= {26'b0, dvs_i});

  always_ff @(posedge clk) begin
    if (en) begin
      y_r    <= t_i.tm * t_i.x2;
      x2a_r  <= t_i.x2;
      suma_r <= t_i.sum;
      y30_r  <= y_r[62:30];
      pq_r   <= y_r[62:30] * rcp_i;
      x2b_r  <= x2a_r;
      sumb_r <= suma_r;
      t_r.tm <= q;
      t_r.x2 <= x2b_r;
      t_r.sum <= sub_i ? sumb_r - $signed({3'b0, q}) : sumb_r + $signed({3'b0, q});
    end
  end

  assign t_o = t_r;

endmodule

### sv/eia_asin_cell.sv
// One successive-approximation cell of the arcsine: tries one angle bit by
// evaluating the sine series of the trial code. Uses eia_pkg and eia_sin_step.

module eia_asin_cell (
  input  logic          clk,
  input  logic          en,
  input  eia_pkg::sar_t s_i,
  output eia_pkg::sar_t s_o
);
  import eia_pkg::*;

  logic [16:0] cand, cand_d;
  logic        ok, take;
  logic [30:0] x;
  logic [61:0] xx;
  sin_t        sv0_r;
  sin_t        sv [SIN_TERMS+1];
  sar_t        dl_r [CELL_DLY];
  logic        ok_r [CELL_DLY];
  sar_t        s_r;

  assign cand = s_i.a | s_i.mask;
  assign ok   = cand <= PI_Q14;
  assign x    = {cand[15:0], 15'b0};
  assign xx   = x * x;

  always_ff @(posedge clk) begin
    if (en) begin
      sv0_r.tm  <= x;
      sv0_r.x2  <= xx[61:30];
      sv0_r.sum <= $signed({3'b0, x});
      dl_r[0]   <= s_i;
      ok_r[0]   <= ok;
      for (int k = 1; k < CELL_DLY; k++) begin
        dl_r[k] <= dl_r[k-1];
        ok_r[k] <= ok_r[k-1];
      end
    end
  end

  assign sv[0] = sv0_r;

  for (genvar j = 0; j < SIN_TERMS; j++) begin : g_term
    eia_sin_step u_step (
      .clk   (clk),
      .en    (en),
      .t_i   (sv[j]),
      .dvs_i (SIN_DVS[j]),
      .rcp_i (SIN_RCP[j]),
      .sub_i ((j % 2) == 0),
      .t_o   (sv[j+1])
    );
  end

  assign cand_d = dl_r[CELL_DLY-1].a | dl_r[CELL_DLY-1].mask;
  assign take   = ok_r[CELL_DLY-1] &&
                  (sv[SIN_TERMS].sum <= $signed({3'b0, dl_r[CELL_DLY-1].tmag}));

  always_ff @(posedge clk) begin
    if (en) begin
      s_r.a    <= take ? cand_d : dl_r[CELL_DLY-1].a;
      s_r.mask <= dl_r[CELL_DLY-1].mask >> 1;
      s_r.tmag <= dl_r[CELL_DLY-1].tmag;
    end
  end

  assign s_o = s_r;

endmodule

### sv/equisolid_incidence_angle.sv
// Equisolid fisheye incidence angle: radius in, angle = 2*asin(t) out.
// It takes one item per cycle while the skid register behind the output is empty.
// The depth is set by the two division chains and the 17 arcsine cells of 23 stages.
// The skid register catches a result on an output stall and closes the input.
// rst_n is synchronous: it empties the pipeline and loads the register defaults.
// Depends on eia_pkg, eia_div_cell, eia_mulq, eia_sin_step and eia_asin_cell.

module equisolid_incidence_angle (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] radius
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] angle
  output logic        out_tuser   // [0] domain_error
);
  import eia_pkg::*;

  logic [19:0] ns_r, fl_r;
  logic [31:0] cf_r [MAX_COEFFS];
  logic        wr, en;
  logic        vld_r [LAT];

  logic [19:0] r_r;
  logic        sat1_in;
  logic        sat1_r [DIV1_N];
  div_t        d1 [DIV1_N+1];
  logic [39:0] u;
  logic [39:0] u_r [U_DLY];
  logic [39:0] u2;
  logic [39:0] u2_r [U_DLY];
  logic [39:0] pw [MAX_COEFFS];
  logic [39:0] cm [MAX_COEFFS];
  logic [39:0] tm [MAX_COEFFS];
  logic signed [43:0] ts [MAX_COEFFS];
  logic signed [43:0] acc_r [ACC_N];

  logic [42:0] sm_r;
  logic        neg_r;
  logic [41:0] pl_r;
  logic [40:0] ph_r;
  logic [62:0] p_r;
  logic        ovf2;
  logic        ovf2_r [DIV2_N];
  logic [1:0]  side1_r [SIDE1_N];
  div_t        d2 [DIV2_N+1];

  logic [30:0] tmag;
  logic        sz, err, tz;
  logic [2:0]  side2_r [SIDE2_N];
  sar_t        sa [SAR_N+1];
  logic [16:0] a_fin, ang;

  logic        out_valid_r, sk_valid_r;
  logic [16:0] out_ang_r, sk_ang_r;
  logic        out_err_r, sk_err_r;

  // Register file
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= 20'd65536;
      fl_r <= 20'd65536;
      for (int i = 0; i < MAX_COEFFS; i++) cf_r[i] <= '0;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_NS:  ns_r     <= cfg_pwdata[19:0];
        REG_FL:  fl_r     <= cfg_pwdata[19:0];
        REG_C0:  cf_r[0]  <= cfg_pwdata;
        REG_C1:  cf_r[1]  <= cfg_pwdata;
        REG_C2:  cf_r[2]  <= cfg_pwdata;
        REG_C3:  cf_r[3]  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_NS:  cfg_prdata = {12'b0, ns_r};
      REG_FL:  cfg_prdata = {12'b0, fl_r};
      REG_C0:  cfg_prdata = cf_r[0];
      REG_C1:  cfg_prdata = cf_r[1];
      REG_C2:  cfg_prdata = cf_r[2];
      REG_C3:  cfg_prdata = cf_r[3];
      default: cfg_prdata = '0;
    endcase
  end

  // Pipeline advance and valid tracking
  assign en        = ~sk_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Normalisation u = radius * 2^30 / norm_scale
  assign sat1_in = (ns_r == 20'b0) || ({10'b0, r_r} >= {ns_r, 10'b0});
  assign d1[0]   = '{rem: {11'b0, r_r[19:10]}, num: {r_r[9:0], 30'b0},
                     quo: '0, den: {1'b0, ns_r}};

  for (genvar g = 0; g < DIV1_N; g++) begin : g_div1
    eia_div_cell u_cell (.clk(clk), .en(en), .d_i(d1[g]), .d_o(d1[g+1]));
  end

  assign u = sat1_r[DIV1_N-1] ? CAP : d1[DIV1_N].quo;

  // Odd powers and coefficient terms
  eia_mulq u_m_u2 (.clk(clk), .en(en), .a_i(u),  .b_i(u),      .p_o(u2));
  eia_mulq u_m_p3 (.clk(clk), .en(en), .a_i(u2), .b_i(u_r[2]), .p_o(pw[0]));

  for (genvar i = 0; i < MAX_COEFFS; i++) begin : g_coef
    assign cm[i] = (i < NUM_COEFFS) ?
                   {8'b0, (cf_r[i][31] ? 32'(-cf_r[i]) : cf_r[i])} : '0;
    eia_mulq u_m_t (.clk(clk), .en(en), .a_i(cm[i]), .b_i(pw[i]), .p_o(tm[i]));
    assign ts[i] = cf_r[i][31] ? -$signed({4'b0, tm[i]}) : $signed({4'b0, tm[i]});
    if (i + 1 < MAX_COEFFS) begin : g_pow
      eia_mulq u_m_p (.clk(clk), .en(en), .a_i(pw[i]), .b_i(u2_r[3*i+2]),
                      .p_o(pw[i+1]));
    end
  end

  for (genvar j = 0; j < ACC_N; j++) begin : g_acc
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) acc_r[0] <= $signed({4'b0, u_r[U_DLY-1]}) + ts[0];
      end
    end else if ((j % 3) == 0) begin : g_add
      always_ff @(posedge clk) begin
        if (en) acc_r[j] <= acc_r[j-1] + ts[j/3];
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) acc_r[j] <= acc_r[j-1];
      end
    end
  end

  // Scaling t = s * norm_scale / (2 * focal_length)
  assign ovf2 = (fl_r == 20'b0) || (p_r >= {11'b0, fl_r, 1'b0, 31'b0});
  assign d2[0] = '{rem: p_r[51:31], num: {p_r[30:0], 9'b0},
                   quo: '0, den: {fl_r, 1'b0}};

  for (genvar g = 0; g < DIV2_N; g++) begin : g_div2
    eia_div_cell u_cell (.clk(clk), .en(en), .d_i(d2[g]), .d_o(d2[g+1]));
  end

  assign tmag = d2[DIV2_N].quo[30:0];
  assign sz   = side1_r[SIDE1_N-1][0];
  assign err  = !sz && (ovf2_r[DIV2_N-1] || (tmag > ONE30));
  assign tz   = sz || (tmag == 31'b0);

  // Arcsine by successive approximation
  assign sa[0] = '{a: '0, mask: TOP_BIT, tmag: tmag};

  for (genvar g = 0; g < SAR_N; g++) begin : g_sar
    eia_asin_cell u_cell (.clk(clk), .en(en), .s_i(sa[g]), .s_o(sa[g+1]));
  end

  assign a_fin = side2_r[SIDE2_N-1][1] ? PI_Q14 :
                 side2_r[SIDE2_N-1][0] ? 17'b0 : sa[SAR_N].a;
  assign ang   = side2_r[SIDE2_N-1][2] ? 17'(-a_fin) : a_fin;

  // Payload registers and delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      r_r       <= in_tdata[19:0];
      sat1_r[0] <= sat1_in;
      for (int k = 1; k < DIV1_N; k++) sat1_r[k] <= sat1_r[k-1];
      u_r[0]  <= u;
      u2_r[0] <= u2;
      for (int k = 1; k < U_DLY; k++) begin
        u_r[k]  <= u_r[k-1];
        u2_r[k] <= u2_r[k-1];
      end
      neg_r <= acc_r[ACC_N-1] < 0;
      sm_r  <= acc_r[ACC_N-1][43] ? 43'(-acc_r[ACC_N-1]) : acc_r[ACC_N-1][42:0];
      pl_r  <= sm_r[21:0] * ns_r;
      ph_r  <= sm_r[42:22] * ns_r;
      p_r   <= {ph_r, 22'b0} + {21'b0, pl_r};
      side1_r[0] <= {neg_r, sm_r == 43'b0};
      for (int k = 1; k < SIDE1_N; k++) side1_r[k] <= side1_r[k-1];
      ovf2_r[0] <= ovf2;
      for (int k = 1; k < DIV2_N; k++) ovf2_r[k] <= ovf2_r[k-1];
      side2_r[0] <= {side1_r[SIDE1_N-1][1], err, tz};
      for (int k = 1; k < SIDE2_N; k++) side2_r[k] <= side2_r[k-1];
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= vld_r[LAT-1];
      end
    end else if (en && vld_r[LAT-1]) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (sk_valid_r) begin
        out_ang_r <= sk_ang_r;
        out_err_r <= sk_err_r;
      end else begin
        out_ang_r <= ang;
        out_err_r <= side2_r[SIDE2_N-1][1];
      end
    end else if (en) begin
      sk_ang_r <= ang;
      sk_err_r <= side2_r[SIDE2_N-1][1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_ang_r};
  assign out_tuser  = out_err_r;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without an output stall");

  a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_ang_r == PI_Q14 || out_ang_r == 17'(-PI_Q14)))
    else $error("domain error without a saturated angle");

endmodule
